// ===== sv/impulse_collision_resolver_macros.svh =====
// Assertion macros for the collision resolver top module.
`ifndef IMPULSE_COLLISION_RESOLVER_MACROS_SVH
`define IMPULSE_COLLISION_RESOLVER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ICR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ICR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/icr_pkg.sv =====
// Types, codes and saturating arithmetic helpers for the collision resolver.
package icr_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_APPLIED     = 3'd0,
    ST_BOTH_STATIC = 3'd1,
    ST_SEPARATING  = 3'd2,
    ST_ZERO_MASS   = 3'd3,
    ST_READ        = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_RESTITUTION = 2'd0,
    CFG_CORR_FRAC   = 2'd1,
    CFG_SLOP        = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        inv_mass;
    logic               is_static;
  } body_t;

  localparam logic [16:0] RESTITUTION_RST = 17'd32768;
  localparam logic [16:0] CORR_FRAC_RST   = 17'd13107;
  localparam logic [16:0] SLOP_RST        = 17'd655;
  localparam logic [32:0] Q_ONE           = 33'd65536;

  localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX_W) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN_W) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

endpackage

// ===== sv/icr_div.sv =====
// Serial restoring divider: floor(num * 65536 / den), saturated to 32 bits.
module icr_div
  import icr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic [30:0]        den,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quot
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [30:0] den_r, den_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic signed [31:0] quot_r, quot_nxt;

  logic [32:0] rem2;
  logic        ge;
  logic [32:0] num_mag;
  logic [48:0] qfix;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    quot_nxt = quot_r;
    rem2     = {rem_r, quo_r[47]};
    ge       = rem2 >= {2'b0, den_r};
    num_mag  = num[31] ? 33'(-sx33(num)) : 33'(sx33(num));
    qfix     = {1'b0, quo_r} + {48'b0, (neg_r && (rem_r != 32'd0))};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd48;
      neg_nxt  = num[31];
      den_nxt  = den;
      rem_nxt  = '0;
      quo_nxt  = {num_mag[31:0], 16'b0};
    end else if (busy_r) begin
      if (cnt_r != 6'd0) begin
        rem_nxt = ge ? 32'(rem2 - {2'b0, den_r}) : rem2[31:0];
        quo_nxt = {quo_r[46:0], ge};
        cnt_nxt = cnt_r - 6'd1;
      end else begin
        // The remainder decides the extra step down for negative quotients.
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (!neg_r) begin
          quot_nxt = (quo_r > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : quo_r[31:0];
        end else begin
          quot_nxt = (qfix > 49'h80000000) ? 32'sh80000000 : 32'(-qfix[31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r  <= neg_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    quot_r <= quot_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== sv/impulse_collision_resolver.sv =====
// A write item is taken while the input is free and gives no result. A read item gives a result,
// and the input is freed as that result is handed over. A solve item gives a result too, and
// the next item can be taken once it is handed over. Most of a solve item's time goes to the
// two serial divisions by the inverse-mass sum. Each gives one quotient bit per cycle for 48
// bits, then a finishing step, then hands the quotient over. The rest goes to single steps of
// the shared multiply/add unit, the table loads, the alias copy and the write-back.
// The input stalls while an item is at work. It also stalls while a finished result waits for
// the previous one to leave.
`include "impulse_collision_resolver_macros.svh"
module impulse_collision_resolver
  import icr_pkg::*;
#(
  parameter int BODY_SLOTS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_body_a_index,
  input  logic [7:0]         in_body_b_index,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_penetration,
  input  logic [30:0]        in_inv_mass,
  input  logic               in_is_static,
  input  logic               in_last_contact,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic               out_batch_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  localparam int IW    = $clog2(BODY_SLOTS);
  localparam int RECIP = ((1 << 20) + BODY_SLOTS - 1) / BODY_SLOTS;

  typedef enum logic [5:0] {
    S_IDLE, S_LDA, S_LDB, S_RX, S_RY, S_MX, S_MY, S_VN, S_MS, S_CHK, S_NEG, S_DEP,
    S_DJ, S_WJ, S_DC, S_WC, S_MAG, S_IX, S_IY, S_CX, S_CY,
    S_AVX1, S_AVX2, S_AVY1, S_AVY2, S_APX1, S_APX2, S_APY1, S_APY2, S_ALIAS,
    S_BVX1, S_BVX2, S_BVY1, S_BVY2, S_BPX1, S_BPX2, S_BPY1, S_BPY2,
    S_WBA, S_WBB, S_OUT
  } state_t;

  // Slot index modulo the table size, by reciprocal multiply and one correction.
  function automatic logic [IW-1:0] slot_of(input logic [7:0] s);
    logic [31:0] p;
    logic [31:0] q;
    logic [31:0] r;
    p = 32'(s) * 32'(RECIP);
    q = p >> 20;
    r = 32'(s) - q * 32'(BODY_SLOTS);
    if (r >= 32'(BODY_SLOTS)) begin
      r = r - 32'(BODY_SLOTS);
    end
    return r[IW-1:0];
  endfunction

  body_t mem [BODY_SLOTS];
  body_t rd_q;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] wr_addr;
  body_t         wr_data;

  state_t state_r, state_nxt;
  logic [16:0] rest_r, frac_r, slop_r;
  logic [1:0]  cmd_r;
  logic [IW-1:0] a_idx_r, b_idx_r;
  logic signed [31:0] nx_r, ny_r, pen_r;
  logic        last_r;
  logic signed [31:0] vax_r, vay_r, pax_r, pay_r, vbx_r, vby_r, pbx_r, pby_r;
  logic [30:0] ia_r, ib_r;
  logic        sa_r, sb_r;
  logic signed [31:0] t1_r, t2_r, vn_r, msum_r, j_r, mag_r, ix_r, iy_r, cx_r, cy_r;
  logic [2:0]  res_st_r;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic signed [31:0] out_vel_x_r, out_vel_y_r, out_pos_x_r, out_pos_y_r;
  logic        out_batch_r;

  logic        in_acc;
  logic        out_free;
  alu_op_t     alu_op;
  logic signed [32:0] opa, opb;
  logic signed [65:0] prod, sumw;
  logic signed [31:0] alu_y;
  logic        div_start, div_busy, div_done;
  logic signed [31:0] div_num, div_q;
  logic signed [31:0] depth;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign depth     = t2_r[31] ? 32'sd0 : t2_r;

  // Shared unit: saturating add, subtract or Q16.16 multiply.
  always_comb begin
    alu_op = ALU_ADD;
    opa    = '0;
    opb    = '0;
    case (state_r)
      S_RX:   begin alu_op = ALU_SUB; opa = sx33(vbx_r); opb = sx33(vax_r); end
      S_RY:   begin alu_op = ALU_SUB; opa = sx33(vby_r); opb = sx33(vay_r); end
      S_MX:   begin alu_op = ALU_MUL; opa = sx33(t1_r); opb = sx33(nx_r); end
      S_MY:   begin alu_op = ALU_MUL; opa = sx33(t2_r); opb = sx33(ny_r); end
      S_VN:   begin alu_op = ALU_ADD; opa = sx33(t1_r); opb = sx33(t2_r); end
      S_MS:   begin alu_op = ALU_ADD; opa = {2'b0, ia_r}; opb = {2'b0, ib_r}; end
      S_CHK:  begin alu_op = ALU_MUL; opa = Q_ONE + {16'b0, rest_r}; opb = sx33(vn_r); end
      S_NEG:  begin alu_op = ALU_SUB; opa = '0; opb = sx33(t1_r); end
      S_DEP:  begin alu_op = ALU_SUB; opa = sx33(pen_r); opb = {16'b0, slop_r}; end
      S_MAG:  begin alu_op = ALU_MUL; opa = sx33(t1_r); opb = {16'b0, frac_r}; end
      S_IX:   begin alu_op = ALU_MUL; opa = sx33(nx_r); opb = sx33(j_r); end
      S_IY:   begin alu_op = ALU_MUL; opa = sx33(ny_r); opb = sx33(j_r); end
      S_CX:   begin alu_op = ALU_MUL; opa = sx33(nx_r); opb = sx33(mag_r); end
      S_CY:   begin alu_op = ALU_MUL; opa = sx33(ny_r); opb = sx33(mag_r); end
      S_AVX1: begin alu_op = ALU_MUL; opa = sx33(ix_r); opb = {2'b0, ia_r}; end
      S_AVX2: begin alu_op = ALU_SUB; opa = sx33(vax_r); opb = sx33(t1_r); end
      S_AVY1: begin alu_op = ALU_MUL; opa = sx33(iy_r); opb = {2'b0, ia_r}; end
      S_AVY2: begin alu_op = ALU_SUB; opa = sx33(vay_r); opb = sx33(t1_r); end
      S_APX1: begin alu_op = ALU_MUL; opa = sx33(cx_r); opb = {2'b0, ia_r}; end
      S_APX2: begin alu_op = ALU_SUB; opa = sx33(pax_r); opb = sx33(t1_r); end
      S_APY1: begin alu_op = ALU_MUL; opa = sx33(cy_r); opb = {2'b0, ia_r}; end
      S_APY2: begin alu_op = ALU_SUB; opa = sx33(pay_r); opb = sx33(t1_r); end
      S_BVX1: begin alu_op = ALU_MUL; opa = sx33(ix_r); opb = {2'b0, ib_r}; end
      S_BVX2: begin alu_op = ALU_ADD; opa = sx33(vbx_r); opb = sx33(t1_r); end
      S_BVY1: begin alu_op = ALU_MUL; opa = sx33(iy_r); opb = {2'b0, ib_r}; end
      S_BVY2: begin alu_op = ALU_ADD; opa = sx33(vby_r); opb = sx33(t1_r); end
      S_BPX1: begin alu_op = ALU_MUL; opa = sx33(cx_r); opb = {2'b0, ib_r}; end
      S_BPX2: begin alu_op = ALU_ADD; opa = sx33(pbx_r); opb = sx33(t1_r); end
      S_BPY1: begin alu_op = ALU_MUL; opa = sx33(cy_r); opb = {2'b0, ib_r}; end
      S_BPY2: begin alu_op = ALU_ADD; opa = sx33(pby_r); opb = sx33(t1_r); end
      default: begin alu_op = ALU_ADD; opa = '0; opb = '0; end
    endcase
    prod  = opa * opb;
    sumw  = (alu_op == ALU_SUB) ? 66'(opa) - 66'(opb) : 66'(opa) + 66'(opb);
    alu_y = sat32((alu_op == ALU_MUL) ? (prod >>> 16) : sumw);
  end

  assign div_start = (state_r == S_DJ) || (state_r == S_DC);
  assign div_num   = (state_r == S_DJ) ? t1_r : depth;

  icr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (msum_r[30:0]),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  // Body table port selection.
  always_comb begin
    rd_addr = (state_r == S_IDLE) ? slot_of(in_body_a_index) : b_idx_r;
    mem_we  = 1'b0;
    wr_addr = a_idx_r;
    wr_data = '{vel_x: vax_r, vel_y: vay_r, pos_x: pax_r, pos_y: pay_r,
                inv_mass: ia_r, is_static: sa_r};
    if (in_acc && (in_command == CMD_WRITE)) begin
      mem_we  = 1'b1;
      wr_addr = slot_of(in_body_a_index);
      wr_data = '{vel_x: in_vec_x, vel_y: in_vec_y, pos_x: in_pos_x, pos_y: in_pos_y,
                  inv_mass: in_inv_mass, is_static: in_is_static};
    end else if (state_r == S_WBA) begin
      mem_we = 1'b1;
    end else if (state_r == S_WBB) begin
      mem_we  = 1'b1;
      wr_addr = b_idx_r;
      wr_data = '{vel_x: vbx_r, vel_y: vby_r, pos_x: pbx_r, pos_y: pby_r,
                  inv_mass: ib_r, is_static: sb_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && ((in_command == CMD_SOLVE) || (in_command == CMD_READ))) begin
          state_nxt = S_LDA;
        end
      end
      S_LDA:  state_nxt = (cmd_r == CMD_READ) ? S_OUT : S_LDB;
      S_LDB:  state_nxt = (rd_q.is_static && sa_r) ? S_OUT : S_RX;
      S_RX:   state_nxt = S_RY;
      S_RY:   state_nxt = S_MX;
      S_MX:   state_nxt = S_MY;
      S_MY:   state_nxt = S_VN;
      S_VN:   state_nxt = S_MS;
      S_MS:   state_nxt = S_CHK;
      S_CHK: begin
        if ((vn_r > 32'sd0) || (msum_r <= 32'sd0)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_NEG;
        end
      end
      S_NEG:  state_nxt = S_DEP;
      S_DEP:  state_nxt = S_DJ;
      S_DJ:   state_nxt = S_WJ;
      S_WJ:   state_nxt = div_done ? S_DC : S_WJ;
      S_DC:   state_nxt = S_WC;
      S_WC:   state_nxt = div_done ? S_MAG : S_WC;
      S_MAG:  state_nxt = S_IX;
      S_IX:   state_nxt = S_IY;
      S_IY:   state_nxt = S_CX;
      S_CX:   state_nxt = S_CY;
      S_CY:   state_nxt = S_AVX1;
      S_AVX1: state_nxt = S_AVX2;
      S_AVX2: state_nxt = S_AVY1;
      S_AVY1: state_nxt = S_AVY2;
      S_AVY2: state_nxt = S_APX1;
      S_APX1: state_nxt = S_APX2;
      S_APX2: state_nxt = S_APY1;
      S_APY1: state_nxt = S_APY2;
      S_APY2: state_nxt = S_ALIAS;
      S_ALIAS: state_nxt = S_BVX1;
      S_BVX1: state_nxt = S_BVX2;
      S_BVX2: state_nxt = S_BVY1;
      S_BVY1: state_nxt = S_BVY2;
      S_BVY2: state_nxt = S_BPX1;
      S_BPX1: state_nxt = S_BPX2;
      S_BPX2: state_nxt = S_BPY1;
      S_BPY1: state_nxt = S_BPY2;
      S_BPY2: state_nxt = S_WBA;
      S_WBA:  state_nxt = S_WBB;
      S_WBB:  state_nxt = S_OUT;
      S_OUT:  state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rest_r      <= RESTITUTION_RST;
      frac_r      <= CORR_FRAC_RST;
      slop_r      <= SLOP_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RESTITUTION: rest_r <= cfg_data;
          CFG_CORR_FRAC:   frac_r <= cfg_data;
          CFG_SLOP:        slop_r <= cfg_data;
          default: ;
        endcase
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    if (in_acc) begin
      cmd_r   <= in_command;
      a_idx_r <= slot_of(in_body_a_index);
      b_idx_r <= slot_of(in_body_b_index);
      nx_r    <= in_vec_x;
      ny_r    <= in_vec_y;
      pen_r   <= in_penetration;
      last_r  <= in_last_contact;
    end

    case (state_r)
      S_LDA: begin
        vax_r <= rd_q.vel_x; vay_r <= rd_q.vel_y;
        pax_r <= rd_q.pos_x; pay_r <= rd_q.pos_y;
        ia_r  <= rd_q.inv_mass; sa_r <= rd_q.is_static;
        res_st_r <= ST_READ;
      end
      S_LDB: begin
        vbx_r <= rd_q.vel_x; vby_r <= rd_q.vel_y;
        pbx_r <= rd_q.pos_x; pby_r <= rd_q.pos_y;
        ib_r  <= rd_q.inv_mass; sb_r <= rd_q.is_static;
        res_st_r <= (rd_q.is_static && sa_r) ? ST_BOTH_STATIC : ST_APPLIED;
      end
      S_RX, S_MX, S_NEG, S_AVX1, S_AVY1, S_APX1, S_APY1,
      S_BVX1, S_BVY1, S_BPX1, S_BPY1: t1_r <= alu_y;
      S_RY, S_MY, S_DEP: t2_r <= alu_y;
      S_VN:  vn_r   <= alu_y;
      S_MS:  msum_r <= alu_y;
      S_CHK: begin
        t1_r <= alu_y;
        if (vn_r > 32'sd0) begin
          res_st_r <= ST_SEPARATING;
        end else if (msum_r <= 32'sd0) begin
          res_st_r <= ST_ZERO_MASS;
        end
      end
      S_WJ:  if (div_done) j_r <= div_q;
      S_WC:  if (div_done) t1_r <= div_q;
      S_MAG: mag_r <= alu_y;
      S_IX:  ix_r  <= alu_y;
      S_IY:  iy_r  <= alu_y;
      S_CX:  cx_r  <= alu_y;
      S_CY:  cy_r  <= alu_y;
      S_AVX2: if (!sa_r) vax_r <= alu_y;
      S_AVY2: if (!sa_r) vay_r <= alu_y;
      S_APX2: if (!sa_r) pax_r <= alu_y;
      S_APY2: if (!sa_r) pay_r <= alu_y;
      S_ALIAS: begin
        // When both contact bodies are the same slot, B's update builds on A's.
        if (a_idx_r == b_idx_r) begin
          vbx_r <= vax_r; vby_r <= vay_r;
          pbx_r <= pax_r; pby_r <= pay_r;
        end
      end
      S_BVX2: if (!sb_r) vbx_r <= alu_y;
      S_BVY2: if (!sb_r) vby_r <= alu_y;
      S_BPX2: if (!sb_r) pbx_r <= alu_y;
      S_BPY2: if (!sb_r) pby_r <= alu_y;
      S_OUT: begin
        if (out_free) begin
          out_status_r <= res_st_r;
          if (cmd_r == CMD_READ) begin
            out_vel_x_r <= vax_r; out_vel_y_r <= vay_r;
            out_pos_x_r <= pax_r; out_pos_y_r <= pay_r;
            out_batch_r <= 1'b0;
          end else begin
            out_vel_x_r <= '0; out_vel_y_r <= '0;
            out_pos_x_r <= '0; out_pos_y_r <= '0;
            out_batch_r <= last_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_vel_x      = out_vel_x_r;
  assign out_vel_y      = out_vel_y_r;
  assign out_pos_x      = out_pos_x_r;
  assign out_pos_y      = out_pos_y_r;
  assign out_batch_done = out_batch_r;

  `ICR_ASSERT_IMPLY(a_out_from_seq, $rose(out_valid_r), $past(state_r) == S_OUT, "result without sequencer")
  `ICR_ASSERT_IMPLY(a_div_idle, div_start, !div_busy, "divider started while busy")
  `ICR_ASSERT_IMPLY(a_div_wait, div_done, (state_r == S_WJ) || (state_r == S_WC), "quotient unclaimed")
  `ICR_ASSERT_ALWAYS(a_wb_solve, !((state_r == S_WBA) || (state_r == S_WBB)) || (cmd_r == CMD_SOLVE), "write-back outside solve")

endmodule
